/* hw/rtl/jes_pkg.sv */
// ----------------------------------------------------------------------------
// jes_pkg
// Types and constants shared by the Jordan exchange step block.
// ----------------------------------------------------------------------------
package jes_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE    = 2'd0,
        CMD_READ     = 2'd1,
        CMD_EXCHANGE = 2'd2,
        CMD_NOP      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_RANGE = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    localparam logic [0:0] REG_ROWS = 1'b0;
    localparam logic [0:0] REG_COLS = 1'b1;
    localparam logic [3:0] ROWS_RESET = 4'd3;
    localparam logic [3:0] COLS_RESET = 4'd4;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_PIV_RD,
        S_PIV_WT,
        S_DIV,
        S_DIV_WT,
        S_SCAN,
        S_RD_A,
        S_RD_AIS,
        S_RD_ARJ,
        S_RD_WT,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_MUL5,
        S_PACK,
        S_WR,
        S_COPY_RD,
        S_COPY_WT,
        S_COPY_WR,
        S_SIMPLE_WT,
        S_OUT
    } state_t;

    // Request to the shared multiply unit: unsigned 32x32 product
    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } mul_req_t;

    // Saturating pack of a sign and a magnitude into Q16.16
    function automatic logic [32:0] pack_sat(input logic neg, input logic [63:0] mag);
        logic [31:0] v;
        logic        s;
        begin
            s = 1'b0;
            if (neg)
            begin
                if (mag > 64'h8000_0000)
                begin
                    v = 32'h8000_0000;
                    s = 1'b1;
                end
                else
                begin
                    v = 32'd0 - mag[31:0];
                end
            end
            else
            begin
                if (mag > 64'h7FFF_FFFF)
                begin
                    v = 32'h7FFF_FFFF;
                    s = 1'b1;
                end
                else
                begin
                    v = mag[31:0];
                end
            end
            pack_sat = {s, v};
        end
    endfunction

endpackage

/* hw/rtl/jes_divider.sv */
// ----------------------------------------------------------------------------
// jes_divider
// Restoring divider, one quotient bit per cycle: (2^32 + m/2) / m, m 32 bit.
// ----------------------------------------------------------------------------
module jes_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [33:0] quotient
);
    localparam int NUM_W = 34;

    logic [NUM_W-1:0] num_reg, num_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      den_reg, den_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [32:0]      trial;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, num_reg[NUM_W-1]};
        if (start)
        begin
            num_next  = 34'h1_0000_0000 + {3'd0, divisor[31:1]};
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = 6'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one numerator bit, subtract if it fits
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 32'(trial - {1'b0, den_reg});
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;
endmodule

/* hw/rtl/jes_mult.sv */
// ----------------------------------------------------------------------------
// jes_mult
// Shared unsigned 32x32 multiplier with a registered 64 bit product.
// ----------------------------------------------------------------------------
module jes_mult (
    input  logic            clk,
    input  jes_pkg::mul_req_t req,
    output logic [63:0]     product
);
    import jes_pkg::*;

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= 64'(req.a) * 64'(req.b);
        end
    end

    assign product = prod_reg;
endmodule

/* hw/rtl/jordan_exchange_step.sv */
// ----------------------------------------------------------------------------
// jordan_exchange_step
// Q16.16 matrix store with element write/read and a Jordan exchange step.
// ----------------------------------------------------------------------------
// An exchange runs the 34-step reciprocal on the divider, then works through
// each element on the shared multiplier into scratch, then copies scratch
// back into the live matrix element by element.
// One transaction at a time: the input stalls until the result is taken.
// Reset clears both memories, one word a cycle, MAX_ROWS*MAX_COLS words each.
module jordan_exchange_step #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  jes_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output jes_pkg::out_item_t   out_data,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [3:0]           cfg_data
);
    import jes_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int NW    = $clog2(65);

    // memories: live matrix and scratch for the exchange result
    logic [31:0] mem [CELLS];
    logic [31:0] scr [CELLS];
    logic [31:0] mem_q, scr_q;
    logic [AW-1:0] mem_raddr, mem_waddr, scr_raddr, scr_waddr;
    logic          mem_we, scr_we;
    logic [31:0]   mem_wdata, scr_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
        begin
            scr[scr_waddr] <= scr_wdata;
        end
        scr_q <= scr[scr_raddr];
    end

    // configuration
    logic [3:0] rows_cfg_reg, cols_cfg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= ROWS_RESET;
            cols_cfg_reg <= COLS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ROWS)
            begin
                rows_cfg_reg <= cfg_data;
            end
            else
            begin
                cols_cfg_reg <= cfg_data;
            end
        end
    end

    // effective sizes: zero acts as one, above maximum acts as maximum
    logic [NW-1:0] nr, nc;
    always_comb
    begin
        if (rows_cfg_reg == 4'd0)
            nr = NW'(1);
        else if (NW'(rows_cfg_reg) > NW'(MAX_ROWS))
            nr = NW'(MAX_ROWS);
        else
            nr = NW'(rows_cfg_reg);
        if (cols_cfg_reg == 4'd0)
            nc = NW'(1);
        else if (NW'(cols_cfg_reg) > NW'(MAX_COLS))
            nc = NW'(MAX_COLS);
        else
            nc = NW'(cols_cfg_reg);
    end

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                 input logic [CW-1:0] c);
        cell_addr = AW'(32'(r) * MAX_COLS + 32'(c));
    endfunction

    // control registers
    state_t        state_reg, state_next;
    logic [AW:0]   clr_reg, clr_next;
    in_item_t      item_reg, item_next;
    logic [RW-1:0] pr_reg, pr_next, i_reg, i_next;
    logic [CW-1:0] pc_reg, pc_next, j_reg, j_next;
    logic signed [31:0] piv_reg, piv_next, p_reg, p_next;
    logic [31:0]   aij_reg, aij_next, ais_reg, ais_next, arj_reg, arj_next;
    logic [63:0]   acc_reg, acc_next;
    logic [63:0]   md_reg, md_next;
    logic          dneg_reg, dneg_next, sat_reg, sat_next;
    logic [31:0]   res_reg, res_next;
    out_item_t     out_reg, out_next;
    logic          ovalid_reg, ovalid_next;

    // shared units
    mul_req_t    mreq;
    logic [63:0] mprod;
    logic        div_start, div_done;
    logic [33:0] div_q;

    jes_mult u_mult (
        .clk     (clk),
        .req     (mreq),
        .product (mprod)
    );

    jes_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (piv_reg[31] ? 32'd0 - piv_reg : piv_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    logic in_row_range, in_col_range, last_cell;
    logic [31:0] mag_a, mag_b, mag_p;
    logic [32:0] packed_v;
    logic [63:0] prod_b;
    logic        neg_a, neg_b;
    logic [64:0] dsum;
    logic [63:0] rnd;

    assign in_row_range = NW'(item_reg.row) < nr;
    assign in_col_range = NW'(item_reg.col) < nc;
    assign last_cell = (NW'(i_reg) == nr - NW'(1)) && (NW'(j_reg) == nc - NW'(1));
    assign mag_p = p_reg[31] ? 32'd0 - p_reg : p_reg;

    // next state and datapath
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        item_next   = item_reg;
        pr_next     = pr_reg;
        pc_next     = pc_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        piv_next    = piv_reg;
        p_next      = p_reg;
        aij_next    = aij_reg;
        ais_next    = ais_reg;
        arj_next    = arj_reg;
        acc_next    = acc_reg;
        md_next     = md_reg;
        dneg_next   = dneg_reg;
        sat_next    = sat_reg;
        res_next    = res_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg;
        mem_raddr   = cell_addr(pr_reg, pc_reg);
        scr_raddr   = cell_addr(i_reg, j_reg);
        mem_we      = 1'b0;
        mem_waddr   = cell_addr(i_reg, j_reg);
        mem_wdata   = res_reg;
        scr_we      = 1'b0;
        scr_waddr   = cell_addr(i_reg, j_reg);
        scr_wdata   = res_reg;
        mreq        = '{start: 1'b0, a: 32'd0, b: 32'd0};
        div_start   = 1'b0;
        mag_a       = 32'd0;
        mag_b       = 32'd0;
        neg_a       = 1'b0;
        neg_b       = 1'b0;
        prod_b      = 64'd0;
        dsum        = 65'd0;
        rnd         = 64'd0;
        packed_v    = 33'd0;

        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                scr_we    = 1'b1;
                mem_waddr = clr_reg[AW-1:0];
                scr_waddr = clr_reg[AW-1:0];
                mem_wdata = 32'd0;
                scr_wdata = 32'd0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(CELLS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && !ovalid_reg)
                begin
                    item_next = in_data;
                    pr_next   = RW'(in_data.row);
                    pc_next   = CW'(in_data.col);
                    state_next = S_PIV_RD;
                end
            end
            S_PIV_RD:
            begin
                // address the element named by row/col
                mem_raddr = cell_addr(pr_reg, pc_reg);
                state_next = S_PIV_WT;
                out_next = '{read_value: 32'd0, status: ST_OK};
                if (item_reg.cmd == CMD_NOP)
                begin
                    state_next = S_OUT;
                end
                else if (!in_row_range || !in_col_range)
                begin
                    out_next.status = ST_RANGE;
                    state_next = S_OUT;
                end
                else if (item_reg.cmd == CMD_WRITE)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cell_addr(pr_reg, pc_reg);
                    mem_wdata = item_reg.value;
                    state_next = S_OUT;
                end
                else if (item_reg.cmd == CMD_READ)
                begin
                    state_next = S_SIMPLE_WT;
                end
            end
            S_SIMPLE_WT:
            begin
                out_next.read_value = mem_q;
                state_next = S_OUT;
            end
            S_PIV_WT:
            begin
                piv_next = mem_q;
                if (mem_q == 32'd0)
                begin
                    out_next.status = ST_ZERO;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WT;
            end
            S_DIV_WT:
            begin
                if (div_done)
                begin
                    packed_v = pack_sat(piv_reg[31], {30'd0, div_q});
                    p_next   = packed_v[31:0];
                    sat_next = packed_v[32];
                    i_next   = '0;
                    j_next   = '0;
                    state_next = S_RD_A;
                end
            end
            S_RD_A:
            begin
                mem_raddr  = cell_addr(i_reg, j_reg);
                state_next = S_RD_AIS;
            end
            S_RD_AIS:
            begin
                aij_next   = mem_q;
                mem_raddr  = cell_addr(i_reg, pc_reg);
                state_next = S_RD_ARJ;
            end
            S_RD_ARJ:
            begin
                ais_next   = mem_q;
                mem_raddr  = cell_addr(pr_reg, j_reg);
                state_next = S_RD_WT;
            end
            S_RD_WT:
            begin
                arj_next   = mem_q;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                // aij*a magnitude, a_rj*p / a_is*p for pivot row/column, p at the pivot
                if (i_reg == pr_reg && j_reg == pc_reg)
                begin
                    res_next   = p_reg;
                    state_next = S_WR;
                end
                else if (i_reg == pr_reg || j_reg == pc_reg)
                begin
                    mag_a = aij_reg[31] ? 32'd0 - aij_reg : aij_reg;
                    mreq  = '{start: 1'b1, a: mag_a, b: mag_p};
                    state_next = S_MUL5;
                end
                else
                begin
                    mag_a = aij_reg[31] ? 32'd0 - aij_reg : aij_reg;
                    mag_b = piv_reg[31] ? 32'd0 - piv_reg : piv_reg;
                    mreq  = '{start: 1'b1, a: mag_a, b: mag_b};
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                neg_a  = aij_reg[31] ^ piv_reg[31];
                acc_next = neg_a ? 64'd0 - mprod : mprod;
                mag_a = ais_reg[31] ? 32'd0 - ais_reg : ais_reg;
                mag_b = arj_reg[31] ? 32'd0 - arj_reg : arj_reg;
                mreq  = '{start: 1'b1, a: mag_a, b: mag_b};
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                // D = aij*a - ais*arj, exact in 65 bits
                neg_b  = ais_reg[31] ^ arj_reg[31];
                prod_b = neg_b ? 64'd0 - mprod : mprod;
                dsum   = {acc_reg[63], acc_reg} - {prod_b[63], prod_b};
                dneg_next = dsum[64];
                md_next   = dsum[64] ? 64'(65'd0 - dsum) : dsum[63:0];
                state_next = S_MUL4;
            end
            S_MUL4:
            begin
                mreq = '{start: 1'b1, a: md_reg[31:0], b: mag_p};
                state_next = S_PACK;
            end
            S_PACK:
            begin
                // low part product already in mprod; keep it, then high part
                acc_next = (mprod + 64'h8000_0000) >> 32;
                mreq = '{start: 1'b1, a: md_reg[63:32], b: mag_p};
                state_next = S_MUL5;
            end
            S_MUL5:
            begin
                if (i_reg == pr_reg || j_reg == pc_reg)
                begin
                    rnd = (mprod + 64'h8000) >> 16;
                    neg_a = (aij_reg[31] ^ p_reg[31]) ^ (j_reg == pc_reg);
                    if (aij_reg == 32'd0 || p_reg == 32'd0)
                        neg_a = (j_reg == pc_reg);
                    packed_v = pack_sat(neg_a, rnd);
                end
                else
                begin
                    rnd = mprod + acc_reg;
                    packed_v = pack_sat(dneg_reg ^ p_reg[31], rnd);
                end
                res_next = packed_v[31:0];
                sat_next = sat_reg | packed_v[32];
                state_next = S_WR;
            end
            S_WR:
            begin
                scr_we    = 1'b1;
                scr_waddr = cell_addr(i_reg, j_reg);
                scr_wdata = res_reg;
                if (last_cell)
                begin
                    i_next = '0;
                    j_next = '0;
                    state_next = S_COPY_RD;
                end
                else
                begin
                    if (NW'(j_reg) == nc - NW'(1))
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    state_next = S_RD_A;
                end
            end
            S_COPY_RD:
            begin
                scr_raddr  = cell_addr(i_reg, j_reg);
                state_next = S_COPY_WT;
            end
            S_COPY_WT:
            begin
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(i_reg, j_reg);
                mem_wdata = scr_q;
                if (last_cell)
                begin
                    out_next.status = sat_reg ? ST_SAT : ST_OK;
                    state_next = S_OUT;
                end
                else
                begin
                    if (NW'(j_reg) == nc - NW'(1))
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    state_next = S_COPY_RD;
                end
            end
            S_OUT:
            begin
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        pr_reg   <= pr_next;
        pc_reg   <= pc_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        piv_reg  <= piv_next;
        p_reg    <= p_next;
        aij_reg  <= aij_next;
        ais_reg  <= ais_next;
        arj_reg  <= arj_next;
        acc_reg  <= acc_next;
        md_reg   <= md_next;
        dneg_reg <= dneg_next;
        sat_reg  <= sat_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // accept only when idle and the result slot is free
    assign in_stall  = !(state_reg == S_IDLE && !ovalid_reg);
    assign out_valid = ovalid_reg;
    assign out_data  = out_reg;
endmodule

/* sim/jordan_exchange_step_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jordan_exchange_step_tb
// Drives element writes, reads, no-ops, size changes and Jordan exchanges into the block under
// random valid/stall timing. A scoreboard keeps its own Q16.16 copy of the
// matrix and predicts every result, which is checked field by field.
// ----------------------------------------------------------------------------
module jordan_exchange_step_tb;
    import jes_pkg::*;

    localparam int NROW       = 8;
    localparam int NCOL       = 8;
    localparam int ITEM_GOAL  = 1400;
    localparam int CYCLE_CAP  = 4000000;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts results of accepted transactions and checks them
    // ------------------------------------------------------------------------
    class exchange_scoreboard;
        logic [31:0] cells [NROW*NCOL];
        logic [3:0]  rows_reg;
        logic [3:0]  cols_reg;
        out_item_t   pending [$];
        int          errors;

        function new();
            foreach (cells[k])
                cells[k] = '0;
            rows_reg = ROWS_RESET;
            cols_reg = COLS_RESET;
            errors   = 0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [3:0] d);
            if (idx == REG_ROWS)
                rows_reg = d;
            else
                cols_reg = d;
        endfunction

        function int span(logic [3:0] v, int max);
            if (v == 0)
                return 1;
            if (v > max)
                return max;
            return v;
        endfunction

        function logic [31:0] sat_pack(bit neg, logic [63:0] mag, inout bit sat);
            if (neg)
            begin
                if (mag > 64'h8000_0000)
                begin
                    mag = 64'h8000_0000;
                    sat = 1'b1;
                end
                return 32'd0 - mag[31:0];
            end
            if (mag > 64'h7FFF_FFFF)
            begin
                mag = 64'h7FFF_FFFF;
                sat = 1'b1;
            end
            return mag[31:0];
        endfunction

        // (x * p) >> 16 with the magnitude rounded, optionally negated
        function logic [31:0] scale_q16(logic [31:0] x, logic [31:0] p, bit negate,
                                        inout bit sat);
            longint      prod;
            logic [63:0] m;
            prod = longint'($signed(x)) * longint'($signed(p));
            m = (prod < 0) ? 64'(-prod) : 64'(prod);
            return sat_pack((prod < 0) != negate, (m + 64'h8000) >> 16, sat);
        endfunction

        // (d * p) >> 32 with d in Q32.32, split into halves like the datapath
        function logic [31:0] scale_wide(logic signed [64:0] d, logic [31:0] p,
                                         inout bit sat);
            logic [64:0] md_full;
            logic [63:0] md, mp, hi, lo, low, m;
            md_full = (d < 0) ? -d : d;
            md  = md_full[63:0];
            mp  = p[31] ? (64'd0 - {{32{1'b1}}, p}) : {32'd0, p};
            hi  = md >> 32;
            lo  = md & 64'hFFFF_FFFF;
            low = lo * mp;
            m   = hi * mp + ((low + 64'h8000_0000) >> 32);
            return sat_pack((d < 0) != p[31], m, sat);
        endfunction

        function out_item_t predict(in_item_t it);
            int               nr, nc, r, c;
            logic [31:0]      a, pw, aij, ais, arj;
            logic [31:0]      next [NROW*NCOL];
            logic [63:0]      ma;
            logic signed [64:0] t1, t2;
            bit               sat;
            out_item_t        res;
            res = '0;
            res.status = ST_OK;
            nr = span(rows_reg, NROW);
            nc = span(cols_reg, NCOL);
            r  = it.row;
            c  = it.col;
            sat = 1'b0;
            if (it.cmd == CMD_NOP)
                return res;
            if (r >= nr || c >= nc)
            begin
                res.status = ST_RANGE;
                return res;
            end
            if (it.cmd == CMD_WRITE)
                cells[r*NCOL + c] = it.value;
            else if (it.cmd == CMD_READ)
                res.read_value = cells[r*NCOL + c];
            else
            begin
                a = cells[r*NCOL + c];
                if (a == 0)
                begin
                    res.status = ST_ZERO;
                    return res;
                end
                ma = a[31] ? (64'd0 - {{32{1'b1}}, a}) : {32'd0, a};
                pw = sat_pack(a[31], ((64'd1 << 32) + (ma >> 1)) / ma, sat);
                next = cells;
                for (int i = 0; i < nr; i++)
                begin
                    for (int j = 0; j < nc; j++)
                    begin
                        aij = cells[i*NCOL + j];
                        if (i == r && j == c)
                            next[i*NCOL + j] = pw;
                        else if (i == r)
                            next[i*NCOL + j] = scale_q16(aij, pw, 1'b0, sat);
                        else if (j == c)
                            next[i*NCOL + j] = scale_q16(aij, pw, 1'b1, sat);
                        else
                        begin
                            ais = cells[i*NCOL + c];
                            arj = cells[r*NCOL + j];
                            t1 = longint'($signed(aij)) * longint'($signed(a));
                            t2 = longint'($signed(ais)) * longint'($signed(arj));
                            next[i*NCOL + j] = scale_wide(t1 - t2, pw, sat);
                        end
                    end
                end
                cells = next;
                if (sat)
                    res.status = ST_SAT;
            end
            return res;
        endfunction

        function void note_input(in_item_t it);
            pending.insert(pending.size(), predict(it));
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("[%0t] mismatch: %s got %h want %h", $time, what, got, want);
        endtask

        task check(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                report("result with no transaction waiting", got.read_value, 0);
                return;
            end
            want = pending.pop_front();
            if (got.read_value !== want.read_value)
                report("read_value", got.read_value, want.read_value);
            if (got.status !== want.status)
                report("status", 32'(got.status), 32'(want.status));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [3:0]  cfg_data = '0;

    exchange_scoreboard sb;
    bit  no_idle = 1'b0;
    int  cycles = 0;
    int  sent = 0;

    jordan_exchange_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Hard stop: covers the slowest legal run many times over
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Monitor both channels at the rising edge; inputs only move at the
    // falling edge, so the values seen here are stable.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(in_data);
            if (out_valid === 1'b1 && !out_stall)
                sb.check(out_data);
        end
    end

    // Result side: hold stall for a random number of cycles, then take one
    // transaction. Stretches without idling come from no_idle.
    initial
    begin
        int n;
        forever
        begin
            n = no_idle ? 0 : $urandom_range(0, 18);
            @(negedge clk);
            if (n > 0)
            begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------

    // Offer one transaction after a random gap; leave valid high on return so
    // back-to-back transactions need no drop in between.
    task send_item(logic [1:0] cmd, int r, int c, logic [31:0] v);
        int       n;
        in_item_t it;
        it.cmd   = cmd;
        it.row   = r[2:0];
        it.col   = c[2:0];
        it.value = v;
        n = no_idle ? 0 : $urandom_range(0, 18);
        @(negedge clk);
        if (n > 0)
        begin
            in_valid = 1'b0;
            repeat (n) @(negedge clk);
        end
        in_data  = it;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (cmd != CMD_NOP)
            sent++;
    endtask

    // Drop valid and hold off until every expected result has arrived
    task drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task write_cfg(logic [0:0] idx, logic [3:0] d);
        drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.write_reg(idx, d);
    endtask

    function logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($urandom_range(0, 8)) << 16;
            2: return 32'd0 - (32'($urandom_range(1, 8)) << 16);
            3:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'd1;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'd0;
                endcase
            end
            default: return 32'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int nr, nc, phase, r, c, k;
        logic [3:0] rv, cv;
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset sizes are 3 rows by 4 columns
        no_idle = 1'b1;
        send_item(CMD_READ,     0, 0, 32'd0);           // cleared store
        send_item(CMD_EXCHANGE, 1, 1, 32'd0);           // zero pivot
        send_item(CMD_WRITE,    0, 0, 32'h7FFF_FFFF);
        send_item(CMD_WRITE,    2, 3, 32'h8000_0000);
        send_item(CMD_READ,     0, 0, 32'd0);
        send_item(CMD_READ,     2, 3, 32'hFFFF_FFFF);
        send_item(CMD_WRITE,    3, 0, 32'h1234_5678);   // row outside size
        send_item(CMD_READ,     0, 4, 32'd0);           // column outside size
        send_item(CMD_EXCHANGE, 7, 7, 32'd0);
        send_item(CMD_NOP,      5, 2, 32'hDEAD_BEEF);   // unused command
        send_item(CMD_WRITE,    1, 1, 32'h0001_0000);
        send_item(CMD_WRITE,    0, 1, 32'h0002_0000);
        send_item(CMD_WRITE,    1, 0, 32'hFFFD_0000);
        send_item(CMD_EXCHANGE, 1, 1, 32'd0);
        send_item(CMD_READ,     0, 0, 32'd0);
        send_item(CMD_READ,     1, 0, 32'd0);
        no_idle = 1'b0;
        send_item(CMD_WRITE,    1, 1, 32'd1);           // reciprocal saturates
        send_item(CMD_EXCHANGE, 1, 1, 32'd0);
        send_item(CMD_WRITE,    2, 2, 32'h8000_0000);
        send_item(CMD_EXCHANGE, 2, 2, 32'd0);
        send_item(CMD_WRITE,    0, 3, 32'hFFFF_FFFF);
        send_item(CMD_EXCHANGE, 0, 3, 32'd0);
        send_item(CMD_READ,     2, 2, 32'd0);

        // Random phases: new sizes, fill, exchange, read back, some noise
        phase = 0;
        while (sent < ITEM_GOAL)
        begin
            case ($urandom_range(0, 15))
                0:       begin rv = 4'd8; cv = 4'd8; end
                1:       begin rv = 4'd0; cv = 4'($urandom_range(9, 15)); end
                2:       begin rv = 4'($urandom_range(9, 15)); cv = 4'd0; end
                3:       begin rv = 4'd1; cv = 4'd1; end
                default:
                begin
                    rv = 4'($urandom_range(1, 4));
                    cv = 4'($urandom_range(1, 4));
                end
            endcase
            write_cfg(REG_ROWS, rv);
            write_cfg(REG_COLS, cv);
            nr = sb.span(rv, NROW);
            nc = sb.span(cv, NCOL);
            no_idle = ($urandom_range(0, 3) == 0);

            for (int i = 0; i < nr; i++)
                for (int j = 0; j < nc; j++)
                    send_item(CMD_WRITE, i, j, pick_value());

            k = $urandom_range(1, 4);
            for (int e = 0; e < k; e++)
            begin
                r = $urandom_range(0, nr - 1);
                c = $urandom_range(0, nc - 1);
                if ($urandom_range(0, 2) == 0)
                    send_item(CMD_WRITE, r, c, pick_value());
                send_item(CMD_EXCHANGE, r, c, 32'd0);
                if (phase == 5 && e == 0)
                    drain();                            // let everything settle
                send_item(CMD_READ, $urandom_range(0, nr - 1),
                          $urandom_range(0, nc - 1), $urandom());
            end

            for (int i = 0; i < nr; i++)
                for (int j = 0; j < nc; j++)
                    if ($urandom_range(0, 1) == 0)
                        send_item(CMD_READ, i, j, $urandom());

            // Noise: any command at any index, often outside the active size
            k = $urandom_range(0, 3);
            for (int e = 0; e < k; e++)
                send_item(2'($urandom_range(0, 3)), $urandom_range(0, 7),
                          $urandom_range(0, 7), $urandom());
            phase++;
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
